/* rtl/core/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LOM_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("lom check failed");

// Next-cycle implication.
`define LOM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("lom check failed");

`endif

/* rtl/core/lom_pkg.sv */
`default_nettype none

package lom_pkg;

	localparam int SLOT_IDX_W = 6;

	localparam logic [1:0] OP_MATCH  = 2'd0;
	localparam logic [1:0] OP_REST   = 2'd1;
	localparam logic [1:0] OP_CANCEL = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	localparam logic [2:0] KIND_TRADE     = 3'd0;
	localparam logic [2:0] KIND_RESTED    = 3'd1;
	localparam logic [2:0] KIND_FULL      = 3'd2;
	localparam logic [2:0] KIND_DUPLICATE = 3'd3;
	localparam logic [2:0] KIND_CANCELLED = 3'd4;
	localparam logic [2:0] KIND_NOT_FOUND = 3'd5;
	localparam logic [2:0] KIND_DONE      = 3'd6;

	typedef struct packed {
		logic [1:0]         operation;
		logic [31:0]        order_id;
		logic               is_buy;
		logic signed [31:0] price;
		logic [31:0]        quantity;
	} req_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [31:0]        buy_id;
		logic [31:0]        sell_id;
		logic signed [31:0] trade_price;
		logic [31:0]        amount;
		logic               last;
	} rsp_t;

	// broadcast to every cell during a sweep
	typedef struct packed {
		logic        buy;
		logic [31:0] id;
		logic [31:0] arrival;
	} query_t;

	typedef enum logic [3:0] {
		CMD_NONE  = 4'b0001,
		CMD_WRITE = 4'b0010,
		CMD_QTY   = 4'b0100,
		CMD_CLEAR = 4'b1000
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t                op;
		logic [SLOT_IDX_W-1:0]  idx;
		logic [31:0]            id;
		logic signed [31:0]     price;
		logic [31:0]            qty;
		logic                   side;
		logic [31:0]            stamp;
	} cmd_t;

	// sweep record handed from cell to cell
	typedef struct packed {
		logic                   best_vld;
		logic [SLOT_IDX_W-1:0]  best_idx;
		logic [31:0]            best_id;
		logic signed [31:0]     best_price;
		logic [31:0]            best_qty;
		logic [31:0]            best_age;
		logic                   hit_vld;
		logic [SLOT_IDX_W-1:0]  hit_idx;
		logic                   free_vld;
		logic [SLOT_IDX_W-1:0]  free_idx;
	} carry_t;

endpackage

`default_nettype wire

/* rtl/core/lom_cell.sv */
`default_nettype none

module lom_cell import lom_pkg::*; #(
	parameter int INDEX = 0
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire query_t query,
	input  wire cmd_t   cmd,
	input  wire carry_t carry_in,
	output carry_t      carry_out
);

	localparam logic [SLOT_IDX_W-1:0] MY_IDX = SLOT_IDX_W'(INDEX);

	logic               vld_q;
	logic [31:0]        id_q;
	logic signed [31:0] price_q;
	logic [31:0]        qty_q;
	logic               side_q;
	logic [31:0]        stamp_q;

	logic        sel;
	logic [31:0] age;
	logic        elig;
	logic        better;
	carry_t      carry_d;

	assign sel = (cmd.idx == MY_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (sel) begin
			unique case (cmd.op)
				CMD_WRITE: vld_q <= 1'b1;
				CMD_QTY:   vld_q <= (cmd.qty != 32'd0);
				CMD_CLEAR: vld_q <= 1'b0;
				default:   vld_q <= vld_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sel && cmd.op == CMD_WRITE) begin
			id_q    <= cmd.id;
			price_q <= cmd.price;
			qty_q   <= cmd.qty;
			side_q  <= cmd.side;
			stamp_q <= cmd.stamp;
		end else if (sel && cmd.op == CMD_QTY) begin
			qty_q <= cmd.qty;
		end
	end

	assign age  = query.arrival - stamp_q;
	assign elig = vld_q && (side_q != query.buy);

	always_comb begin
		if (price_q != carry_in.best_price) begin
			better = query.buy ? (price_q < carry_in.best_price)
			                   : (price_q > carry_in.best_price);
		end else begin
			better = age > carry_in.best_age;
		end
	end

	always_comb begin
		carry_d = carry_in;
		if (elig && (!carry_in.best_vld || better)) begin
			carry_d.best_vld   = 1'b1;
			carry_d.best_idx   = MY_IDX;
			carry_d.best_id    = id_q;
			carry_d.best_price = price_q;
			carry_d.best_qty   = qty_q;
			carry_d.best_age   = age;
		end
		if (vld_q && !carry_in.hit_vld && id_q == query.id) begin
			carry_d.hit_vld = 1'b1;
			carry_d.hit_idx = MY_IDX;
		end
		if (!vld_q && !carry_in.free_vld) begin
			carry_d.free_vld = 1'b1;
			carry_d.free_idx = MY_IDX;
		end
	end

	always_ff @(posedge clk) begin
		carry_out <= carry_d;
	end

endmodule

`default_nettype wire

/* rtl/core/lom_ctrl.sv */
`default_nettype none

module lom_ctrl import lom_pkg::*; #(
	parameter int ORDER_SLOTS = 32
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   req_valid,
	output logic        req_ready,
	input  wire req_t   req,
	output logic        rsp_valid,
	input  wire logic   rsp_ready,
	output rsp_t        rsp,
	output query_t      query,
	output cmd_t        cmd,
	input  wire carry_t result
);

	localparam int CW = $clog2(ORDER_SLOTS + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t             st_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      n_q;
	logic [31:0]        arrival_q;
	logic               out_vld_q;
	rsp_t               out_q;

	logic [1:0]         op_q;
	logic [31:0]        id_q;
	logic               buy_q;
	logic signed [31:0] price_q;
	logic [31:0]        qty_q;

	logic        take_req;
	logic        out_free;
	logic        scan_done;
	logic        act;
	logic [31:0] fill;
	logic        crosses;
	logic        match_go;
	rsp_t        rsp_d;
	cmd_t        cmd_d;

	assign req_ready = (st_q == ST_IDLE);
	assign take_req  = req_valid && req_ready;
	assign out_free  = !out_vld_q || rsp_ready;
	assign scan_done = (cnt_q == CW'(ORDER_SLOTS));
	assign act       = (st_q == ST_SCAN) && scan_done && out_free;

	assign fill     = (qty_q < result.best_qty) ? qty_q : result.best_qty;
	assign crosses  = buy_q ? (price_q >= result.best_price) : (price_q <= result.best_price);
	assign match_go = (qty_q != 32'd0) && (n_q != CW'(ORDER_SLOTS)) && result.best_vld
		&& crosses;

	assign query.buy     = buy_q;
	assign query.id      = id_q;
	assign query.arrival = arrival_q;

	always_comb begin
		rsp_d             = '0;
		rsp_d.buy_id      = id_q;
		rsp_d.last        = 1'b1;
		cmd_d             = '0;
		cmd_d.op          = CMD_NONE;
		cmd_d.id          = id_q;
		cmd_d.price       = price_q;
		cmd_d.qty         = qty_q;
		cmd_d.side        = buy_q;
		cmd_d.stamp       = arrival_q;
		unique case (op_q)
			OP_MATCH: begin
				if (match_go) begin
					rsp_d.kind        = KIND_TRADE;
					rsp_d.buy_id      = buy_q ? id_q : result.best_id;
					rsp_d.sell_id     = buy_q ? result.best_id : id_q;
					rsp_d.trade_price = result.best_price;
					rsp_d.amount      = fill;
					rsp_d.last        = 1'b0;
					cmd_d.op          = CMD_QTY;
					cmd_d.idx         = result.best_idx;
					cmd_d.qty         = result.best_qty - fill;
				end else begin
					rsp_d.kind        = KIND_DONE;
					rsp_d.trade_price = price_q;
					rsp_d.amount      = qty_q;
				end
			end
			OP_REST: begin
				rsp_d.trade_price = price_q;
				rsp_d.amount      = qty_q;
				if (result.hit_vld) begin
					rsp_d.kind = KIND_DUPLICATE;
				end else if (!result.free_vld) begin
					rsp_d.kind = KIND_FULL;
				end else begin
					rsp_d.kind = KIND_RESTED;
					cmd_d.op   = CMD_WRITE;
					cmd_d.idx  = result.free_idx;
				end
			end
			OP_CANCEL: begin
				if (result.hit_vld) begin
					rsp_d.kind = KIND_CANCELLED;
					cmd_d.op   = CMD_CLEAR;
					cmd_d.idx  = result.hit_idx;
				end else begin
					rsp_d.kind = KIND_NOT_FOUND;
				end
			end
			default: rsp_d.kind = KIND_NOT_FOUND;
		endcase
	end

	always_comb begin
		cmd = cmd_d;
		if (!act) begin
			cmd.op = CMD_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			cnt_q     <= '0;
			n_q       <= '0;
			arrival_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (act) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && rsp_ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (take_req && req.operation != OP_NONE) begin
						st_q  <= ST_SCAN;
						cnt_q <= '0;
						n_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (!scan_done) begin
						cnt_q <= cnt_q + CW'(1);
					end else if (out_free) begin
						if (op_q == OP_MATCH && match_go) begin
							n_q   <= n_q + CW'(1);
							cnt_q <= '0;
						end else begin
							st_q <= ST_IDLE;
						end
						if (cmd_d.op == CMD_WRITE) begin
							arrival_q <= arrival_q + 32'd1;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take_req) begin
			op_q    <= req.operation;
			id_q    <= req.order_id;
			buy_q   <= req.is_buy;
			price_q <= req.price;
			qty_q   <= req.quantity;
		end else if (act && op_q == OP_MATCH && match_go) begin
			qty_q <= qty_q - fill;
		end
		if (act) begin
			out_q <= rsp_d;
		end
	end

	assign rsp_valid = out_vld_q;
	assign rsp       = out_q;

endmodule

`default_nettype wire

/* rtl/core/limit_order_matcher.sv */
// Price-time priority limit order book over a row of order cells.
// Request channel (req_valid/req_ready/req): one beat per command:
//   match an aggressive order, rest an order, or cancel by id.
//   Operation code 3 is taken and gives no response.
// Response channel (rsp_valid/rsp_ready/rsp): one or more beats per
//   command, the final one flagged by rsp.last. A match gives one trade
//   beat per fill, then a done beat with the unfilled quantity.
// Each lookup is a sweep of a record through the ORDER_SLOTS cells, one
//   cell per cycle. A match sweeps once after the command and once more
//   after each fill; rest and cancel take a single sweep.
// One command is in the book at a time; req_ready is low from accept of
//   a code other than 3 until its last beat enters the output register.
// A stalled receiver holds the output register; the sweep then waits
//   with its result and the book does not change.
// Reset empties the book and zeroes the arrival counter; no clearing
//   pass is needed.
`default_nettype none

module limit_order_matcher import lom_pkg::*; #(
	parameter int ORDER_SLOTS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	query_t query;
	cmd_t   cmd;
	carry_t chain [ORDER_SLOTS+1];

	assign chain[0] = '0;

	lom_ctrl #(
		.ORDER_SLOTS(ORDER_SLOTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.query     (query),
		.cmd       (cmd),
		.result    (chain[ORDER_SLOTS])
	);

	for (genvar i = 0; i < ORDER_SLOTS; i++) begin : g_cell
		lom_cell #(
			.INDEX(i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.query     (query),
			.cmd       (cmd),
			.carry_in  (chain[i]),
			.carry_out (chain[i+1])
		);
	end

endmodule

`default_nettype wire

/* rtl/core/lom_checker.sv */
`default_nettype none

`include "assert_macros.svh"

module lom_checker import lom_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire req_t req,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp
);

	`LOM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
	`LOM_ASSERT_NEXT(a_busy_after_cmd, req_valid && req_ready && req.operation != OP_NONE,
		!req_ready)
	`LOM_ASSERT(a_single_last, rsp_valid && rsp.kind != KIND_TRADE, rsp.last)
	`LOM_ASSERT(a_trade_not_last, rsp_valid && rsp.kind == KIND_TRADE, !rsp.last)

endmodule

bind limit_order_matcher lom_checker u_lom_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

`default_nettype wire

/* sim/limit_order_matcher_tb.sv */
`default_nettype none

module limit_order_matcher_tb;
	import lom_pkg::*;

	localparam int SLOTS = 32;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	limit_order_matcher #(.ORDER_SLOTS(SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	// book model
	logic              bk_valid [SLOTS];
	logic [31:0]       bk_id [SLOTS];
	logic signed [31:0] bk_price [SLOTS];
	logic [31:0]       bk_qty [SLOTS];
	logic              bk_side [SLOTS];
	logic [31:0]       bk_stamp [SLOTS];
	logic [31:0]       arrivals;

	req_t pending_cmds[$];
	rsp_t expected_beats[$];
	int   errors;
	int   send_idle_pct;
	int   recv_stall_pct;
	logic [31:0] id_pool [16];

	task automatic expect_beat(rsp_t b);
		expected_beats = {expected_beats, b};
	endtask

	task automatic queue_cmd(req_t c);
		pending_cmds = {pending_cmds, c};
	endtask

	function automatic rsp_t mk_beat(logic [2:0] k, logic [31:0] b, logic [31:0] s,
		logic signed [31:0] p, logic [31:0] a, logic l);
		rsp_t r;
		r.kind = k;
		r.buy_id = b;
		r.sell_id = s;
		r.trade_price = p;
		r.amount = a;
		r.last = l;
		return r;
	endfunction

	function automatic int lookup_id(logic [31:0] id);
		for (int i = 0; i < SLOTS; i++)
			if (bk_valid[i] && bk_id[i] == id)
				return i;
		return -1;
	endfunction

	function automatic int best_resting(logic buy);
		int best;
		logic better;
		logic [31:0] ai, ab;
		best = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (!bk_valid[i] || bk_side[i] == buy)
				continue;
			if (best < 0) begin
				better = 1'b1;
			end else if (bk_price[i] != bk_price[best]) begin
				better = buy ? (bk_price[i] < bk_price[best]) : (bk_price[i] > bk_price[best]);
			end else begin
				ai = arrivals - bk_stamp[i];
				ab = arrivals - bk_stamp[best];
				better = ai > ab;
			end
			if (better)
				best = i;
		end
		return best;
	endfunction

	task automatic predict_book(req_t c);
		logic [31:0] qty, fill;
		int b, n, s;
		qty = c.quantity;
		n = 0;
		case (c.operation)
			OP_MATCH: begin
				while (qty > 0 && n < SLOTS) begin
					b = best_resting(c.is_buy);
					if (b < 0)
						break;
					if (c.is_buy ? (c.price < bk_price[b]) : (c.price > bk_price[b]))
						break;
					fill = qty < bk_qty[b] ? qty : bk_qty[b];
					expect_beat(mk_beat(KIND_TRADE,
						c.is_buy ? c.order_id : bk_id[b],
						c.is_buy ? bk_id[b] : c.order_id, bk_price[b], fill, 1'b0));
					n++;
					qty -= fill;
					bk_qty[b] -= fill;
					if (bk_qty[b] == 0)
						bk_valid[b] = 1'b0;
				end
				expect_beat(mk_beat(KIND_DONE, c.order_id, 0, c.price, qty, 1'b1));
			end
			OP_REST: begin
				s = -1;
				for (int i = SLOTS - 1; i >= 0; i--)
					if (!bk_valid[i])
						s = i;
				if (lookup_id(c.order_id) >= 0) begin
					expect_beat(mk_beat(KIND_DUPLICATE, c.order_id, 0, c.price,
						c.quantity, 1'b1));
				end else if (s < 0) begin
					expect_beat(mk_beat(KIND_FULL, c.order_id, 0, c.price,
						c.quantity, 1'b1));
				end else begin
					bk_valid[s] = 1'b1;
					bk_id[s] = c.order_id;
					bk_price[s] = c.price;
					bk_qty[s] = c.quantity;
					bk_side[s] = c.is_buy;
					bk_stamp[s] = arrivals;
					arrivals++;
					expect_beat(mk_beat(KIND_RESTED, c.order_id, 0, c.price,
						c.quantity, 1'b1));
				end
			end
			OP_CANCEL: begin
				s = lookup_id(c.order_id);
				if (s < 0) begin
					expect_beat(mk_beat(KIND_NOT_FOUND, c.order_id, 0, 0, 0, 1'b1));
				end else begin
					bk_valid[s] = 1'b0;
					expect_beat(mk_beat(KIND_CANCELLED, c.order_id, 0, 0, 0, 1'b1));
				end
			end
			default: ;
		endcase
	endtask

	function automatic req_t mk_cmd(logic [1:0] op, logic [31:0] id, logic buy,
		logic signed [31:0] p, logic [31:0] q);
		req_t c;
		c.operation = op;
		c.order_id = id;
		c.is_buy = buy;
		c.price = p;
		c.quantity = q;
		return c;
	endfunction

	// random commands drawn around a narrow price band so orders cross
	function automatic req_t random_cmd();
		int r;
		logic [1:0] op;
		logic [31:0] id, q;
		logic signed [31:0] p;
		r = $urandom_range(99);
		op = r < 40 ? OP_REST : r < 75 ? OP_MATCH : r < 95 ? OP_CANCEL : OP_NONE;
		id = ($urandom_range(9) == 0) ? $urandom : id_pool[$urandom_range(15)];
		p = ($urandom_range(19) == 0) ? $urandom : 32'sd100 + $signed($urandom_range(10)) - 5;
		case ($urandom_range(9))
			0: q = $urandom;
			1: q = 0;
			default: q = $urandom_range(1, 20);
		endcase
		return mk_cmd(op, id, 1'($urandom_range(1)), p, q);
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && req_ready)
				predict_book(req);
			if (!req_valid || req_ready) begin
				if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					req_valid <= 1'b1;
					req <= pending_cmds.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_beat;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_beats.size() == 0) begin
					$display("%0t: unexpected beat %p", $time, rsp);
					errors++;
				end else begin
					exp_beat = expected_beats.pop_front();
					if (rsp !== exp_beat) begin
						$display("%0t: mismatch expected %p actual %p", $time, exp_beat, rsp);
						errors++;
					end
				end
			end
			rsp_ready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	task automatic wait_drained();
		while (pending_cmds.size() > 0 || req_valid || expected_beats.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	initial begin
		errors = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arrivals = 0;
		for (int i = 0; i < SLOTS; i++)
			bk_valid[i] = 1'b0;
		for (int i = 0; i < 16; i++)
			id_pool[i] = $urandom;
		id_pool[0] = 32'h0;
		id_pool[1] = 32'hFFFF_FFFF;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, every kind of answer, fill of a full book
		queue_cmd(mk_cmd(OP_MATCH, 32'h0, 1'b1, 32'sh7FFF_FFFF, 32'd5));
		queue_cmd(mk_cmd(OP_MATCH, 32'h7, 1'b0, 32'sh8000_0000, 32'd0));
		queue_cmd(mk_cmd(OP_REST, 32'hFFFF_FFFF, 1'b0, 32'sh8000_0000,
			32'hFFFF_FFFF));
		queue_cmd(mk_cmd(OP_REST, 32'hFFFF_FFFF, 1'b1, 32'sd3, 32'd1));
		queue_cmd(mk_cmd(OP_REST, 32'h1, 1'b0, 32'sh8000_0000, 32'd0));
		queue_cmd(mk_cmd(OP_REST, 32'h2, 1'b1, 32'sh7FFF_FFFF, 32'd4));
		queue_cmd(mk_cmd(OP_MATCH, 32'h3, 1'b1, 32'sh7FFF_FFFF, 32'd10));
		queue_cmd(mk_cmd(OP_MATCH, 32'hAAAA_5555, 1'b0, 32'sh8000_0000,
			32'hFFFF_FFFF));
		queue_cmd(mk_cmd(OP_CANCEL, 32'h2, 1'b0, 32'sd0, 32'd0));
		queue_cmd(mk_cmd(OP_CANCEL, 32'hFFFF_FFFF, 1'b0, 32'sd0, 32'd0));
		queue_cmd(mk_cmd(OP_NONE, 32'h5555_AAAA, 1'b1, -32'sd1, 32'd9));
		wait_drained();
		for (int i = 0; i < SLOTS + 1; i++)
			queue_cmd(mk_cmd(OP_REST, 32'h100 + i, 1'b0, 32'sd50 + (i % 3),
				32'd1));
		// sweeps the whole book: one trade per resting order
		queue_cmd(mk_cmd(OP_MATCH, 32'h200, 1'b1, 32'sd60, 32'd40));
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 71 : 33) : 0;
			recv_stall_pct = (ph == 2) ? 71 : (ph == 3) ? 33 : 0;
			for (int i = 0; i < 32; i++)
				queue_cmd(random_cmd());
			wait_drained();
		end

		if (errors == 0)
			$display("** limit_order_matcher: PASSED **");
		else
			$display("** limit_order_matcher: FAILED **");
		$finish;
	end

	initial begin
		#4000000;
		$display("** limit_order_matcher: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl/core
rtl/core/lom_pkg.sv
rtl/core/lom_cell.sv
rtl/core/lom_ctrl.sv
rtl/core/limit_order_matcher.sv
rtl/core/lom_checker.sv
sim/limit_order_matcher_tb.sv
